>>> hdl/fcam_pkg.sv
`default_nettype none
package fcam_pkg;

  localparam int CURSOR_BITS_DEF   = 12;
  localparam int POSITION_BITS_DEF = 32;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOOK_SENS  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_SPEED = 1'd1;

  localparam logic [15:0] LOOK_SENS_RST  = 16'd26;
  localparam logic [15:0] MOVE_SPEED_RST = 16'd640;

  localparam int CURSOR_X_RST = 400;
  localparam int CURSOR_Y_RST = 300;

  // Angles are Q9.16 degrees; the wrapped sum needs a few extra bits.
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] DEG_HALF    = 34'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_FULL    = 34'sd23592960;
  localparam logic signed [ANG_W-1:0] DEG_QUARTER = 34'sd5898240;
  localparam logic signed [ANG_W-1:0] PITCH_LIM   = 34'sd5832704;
  localparam logic signed [ANG_W-1:0] YAW_RST     = -34'sd5898240;

  // A full turn is 45 * 2^19 in Q16 degrees. The raw yaw delta is scaled by
  // 2^8, so only its count of 2^11 units needs reducing modulo 45. The
  // offset is a multiple of 45 that keeps that count positive, and the
  // reciprocal is exact for counts below 2^23.
  localparam int          WRAP_OFS   = 2097180;
  localparam logic [23:0] WRAP_RECIP = 24'd11930465;
  localparam logic [22:0] TURN_DIV   = 23'd45;

  // CORDIC datapath in Q2.30.
  localparam int CW = 33;
  localparam int CORDIC_STEPS = 18;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032875;

  localparam logic OP_MOUSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Queue entry between front and back. The angle deltas are cursor delta
  // times sensitivity, before the scaling by 2^8.
  typedef struct packed {
    logic        is_tick;
    logic        first_move;
    logic [31:0] step;
    logic [3:0]  keys;
    logic signed [ANG_W-1:0] yaw_delta;
    logic signed [ANG_W-1:0] pitch_delta;
  } fcam_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRAP, ST_ANGLE, ST_COS_YAW, ST_COS_PITCH, ST_DIR_X, ST_DIR_Z,
    ST_MOVE_F, ST_MOVE_B, ST_MOVE_L, ST_MOVE_R, ST_OUT
  } fcam_state_t;

  function automatic logic signed [CW-1:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:  atan_q16 = 33'sd2949120;
      5'd1:  atan_q16 = 33'sd1740967;
      5'd2:  atan_q16 = 33'sd919879;
      5'd3:  atan_q16 = 33'sd466945;
      5'd4:  atan_q16 = 33'sd234379;
      5'd5:  atan_q16 = 33'sd117304;
      5'd6:  atan_q16 = 33'sd58666;
      5'd7:  atan_q16 = 33'sd29335;
      5'd8:  atan_q16 = 33'sd14668;
      5'd9:  atan_q16 = 33'sd7334;
      5'd10: atan_q16 = 33'sd3667;
      5'd11: atan_q16 = 33'sd1833;
      5'd12: atan_q16 = 33'sd917;
      5'd13: atan_q16 = 33'sd458;
      5'd14: atan_q16 = 33'sd229;
      5'd15: atan_q16 = 33'sd115;
      5'd16: atan_q16 = 33'sd57;
      5'd17: atan_q16 = 33'sd29;
      default: atan_q16 = '0;
    endcase
  endfunction

  // Round half up from Q30 to Q15 and saturate.
  function automatic logic signed [15:0] q30_to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW-15:0] s;
    t = {v[CW-1], v} + (CW+1)'(16384);
    s = t[CW:15];
    if (s > 32767) q30_to_q15 = 16'sh7fff;
    else if (s < -32768) q30_to_q15 = 16'sh8000;
    else q30_to_q15 = s[15:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/fcam_front.sv
`default_nettype none
module fcam_front
  import fcam_pkg::*;
#(
  parameter int CURSOR_BITS = CURSOR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   opcode,
  input  wire logic [CURSOR_BITS-1:0] cursor_x,
  input  wire logic [CURSOR_BITS-1:0] cursor_y,
  input  wire logic [15:0]            time_step,
  input  wire logic [3:0]             keys_held,
  input  wire logic [15:0]            look_sens,
  input  wire logic [15:0]            move_speed,
  output logic                        cmd_valid,
  input  wire logic                   cmd_ready,
  output fcam_cmd_t                   cmd
);

  logic [CURSOR_BITS-1:0] prev_x_r, prev_y_r;
  logic                   first_r;
  logic                   cmd_valid_r;
  fcam_cmd_t              cmd_r, cmd_nxt;
  logic [CURSOR_BITS-1:0] px, py;
  logic signed [CURSOR_BITS:0] dx, dy;
  logic signed [CURSOR_BITS+17:0] sx, sy;

  // One-entry queue: a new beat may enter as the held one leaves.
  assign in_ready  = !cmd_valid_r || cmd_ready;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  // Classify the beat and form the scaled angle deltas.
  always_comb begin
    px = first_r ? cursor_x : prev_x_r;
    py = first_r ? cursor_y : prev_y_r;
    dx = $signed({1'b0, cursor_x}) - $signed({1'b0, px});
    dy = $signed({1'b0, py}) - $signed({1'b0, cursor_y});
    sx = dx * $signed({1'b0, look_sens});
    sy = dy * $signed({1'b0, look_sens});
    cmd_nxt.is_tick     = (opcode == OP_TICK);
    cmd_nxt.first_move  = first_r;
    cmd_nxt.step        = move_speed * time_step;
    cmd_nxt.keys        = keys_held;
    cmd_nxt.yaw_delta   = ANG_W'(sx);
    cmd_nxt.pitch_delta = ANG_W'(sy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      first_r     <= 1'b1;
      prev_x_r    <= CURSOR_BITS'(CURSOR_X_RST);
      prev_y_r    <= CURSOR_BITS'(CURSOR_Y_RST);
    end else begin
      if (in_ready) cmd_valid_r <= in_valid;
      if (in_valid && in_ready && opcode == OP_MOUSE) begin
        first_r  <= 1'b0;
        prev_x_r <= cursor_x;
        prev_y_r <= cursor_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/fcam_cordic.sv
`default_nettype none
module fcam_cordic
  import fcam_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ANG_W-1:0] angle,
  output logic                         done,
  output logic signed [15:0]           sin_q15,
  output logic signed [15:0]           cos_q15
);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic                 flip_r, busy_r, done_r;
  logic [4:0]           i_r;
  logic signed [CW-1:0] dx, dy, xo, yo, at;
  logic signed [ANG_W-1:0] zf;

  assign done = done_r;

  // Fold into [-90, 90] and one rotation per cycle.
  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = atan_q16(i_r);
    xo = flip_r ? -x_r : x_r;
    yo = flip_r ? -y_r : y_r;
    if (angle > DEG_QUARTER) zf = angle - DEG_HALF;
    else if (angle < -DEG_QUARTER) zf = angle + DEG_HALF;
    else zf = angle;
    sin_q15 = q30_to_q15(yo);
    cos_q15 = q30_to_q15(xo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= CW'(zf);
        flip_r <= (angle > DEG_QUARTER) || (angle < -DEG_QUARTER);
      end else if (busy_r) begin
        if (!z_r[CW-1]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/fcam_back.sv
`default_nettype none
module fcam_back
  import fcam_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire fcam_cmd_t                       cmd,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [15:0]                   view_x,
  output logic signed [15:0]                   view_y,
  output logic signed [15:0]                   view_z,
  output logic signed [POSITION_BITS-1:0]      position_x,
  output logic signed [POSITION_BITS-1:0]      position_y,
  output logic signed [POSITION_BITS-1:0]      position_z
);

  localparam int PW = POSITION_BITS;
  localparam logic signed [PW:0] PMAX = (PW+1)'({1'b0, {(PW-1){1'b1}}});
  localparam logic signed [PW:0] PMIN = -PMAX - (PW+1)'(1);

  fcam_state_t st_r, st_nxt;
  fcam_cmd_t   c_r;
  logic signed [ANG_W-1:0] yaw_r, pitch_r;
  logic signed [15:0] dir_x_r, dir_y_r, dir_z_r;
  logic signed [15:0] sy_r, cy_r, cp_r;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic out_valid_r;
  logic [15:0] vx_o_r, vy_o_r, vz_o_r;
  logic [PW-1:0] px_o_r, py_o_r, pz_o_r;

  logic cs_start, cs_done;
  logic signed [ANG_W-1:0] cs_angle;
  logic signed [15:0] cs_sin, cs_cos;

  fcam_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .angle(cs_angle),
    .done(cs_done), .sin_q15(cs_sin), .cos_q15(cs_cos)
  );

  // Yaw delta modulo one turn: the count of 2^11 units is reduced modulo 45
  // by a reciprocal multiply, registered in the wrap step.
  logic signed [ANG_W-1:0] wa;
  logic [22:0] wu;
  logic [46:0] wprod;
  logic [16:0] wq, wq_r;
  logic [5:0]  wr;
  always_comb begin
    wa    = c_r.yaw_delta >>> 11;
    wu    = 23'(wa + ANG_W'(WRAP_OFS));
    wprod = wu * WRAP_RECIP;
    wq    = wprod[45:29];
    wr    = 6'(wu - {6'b0, wq_r} * TURN_DIV);
  end

  // Angle update combinational helpers.
  logic signed [ANG_W-1:0] yaw_s, yaw_w, pitch_c;
  logic signed [ANG_W+8:0] pitch_s;
  always_comb begin
    // The reduced delta lies within one turn and is not negative.
    yaw_s = yaw_r + $signed({9'b0, wr, c_r.yaw_delta[10:0], 8'b0});
    if (yaw_s >= DEG_HALF) yaw_w = yaw_s - DEG_FULL;
    else yaw_w = yaw_s;
    pitch_s = (ANG_W+9)'(pitch_r) + ((ANG_W+9)'(c_r.pitch_delta) <<< 8);
    if (pitch_s > (ANG_W+9)'(PITCH_LIM)) pitch_c = PITCH_LIM;
    else if (pitch_s < -(ANG_W+9)'(PITCH_LIM)) pitch_c = -PITCH_LIM;
    else pitch_c = pitch_s[ANG_W-1:0];
  end

  // Q1.15 product with rounding, one multiplier.
  logic signed [15:0] ma, mb, mq;
  logic signed [31:0] mp;
  logic signed [32:0] mr;
  always_comb begin
    ma = (st_r == ST_DIR_X) ? cy_r : sy_r;
    mb = cp_r;
    mp = ma * mb;
    mr = {mp[31], mp} + 33'sd16384;
    if ($signed(mr[32:15]) > 18'sd32767) mq = 16'sh7fff;
    else if ($signed(mr[32:15]) < -18'sd32768) mq = 16'sh8000;
    else mq = mr[30:15];
  end

  // Movement: component times step, round, saturating add.
  logic signed [15:0] comp_x, comp_y, comp_z, rx;
  logic sub;
  logic signed [48:0] fx, fy, fz;
  logic signed [PW:0] nx, ny, nz;
  function automatic logic signed [PW:0] sat_add(
    input logic signed [PW-1:0] p, input logic signed [48:0] f, input logic s);
    logic signed [25:0] d;
    logic signed [PW+26:0] t;
    d = f[48:23];
    t = s ? ((PW+27)'(p) - (PW+27)'(d)) : ((PW+27)'(p) + (PW+27)'(d));
    if (t > (PW+27)'(PMAX)) sat_add = PMAX;
    else if (t < (PW+27)'(PMIN)) sat_add = PMIN;
    else sat_add = t[PW:0];
  endfunction
  always_comb begin
    rx = (sy_r == -16'sd32768) ? 16'sh7fff : -sy_r;
    case (st_r)
      ST_MOVE_L, ST_MOVE_R: begin
        comp_x = rx; comp_y = '0; comp_z = cy_r;
      end
      default: begin
        comp_x = dir_x_r; comp_y = dir_y_r; comp_z = dir_z_r;
      end
    endcase
    sub = (st_r == ST_MOVE_B) || (st_r == ST_MOVE_L);
    fx = comp_x * $signed({1'b0, c_r.step}) + 49'sd4194304;
    fy = comp_y * $signed({1'b0, c_r.step}) + 49'sd4194304;
    fz = comp_z * $signed({1'b0, c_r.step}) + 49'sd4194304;
    nx = sat_add(px_r, fx, sub);
    ny = sat_add(py_r, fy, sub);
    nz = sat_add(pz_r, fz, sub);
  end

  // Sequencer.
  always_comb begin
    st_nxt    = st_r;
    cmd_ready = 1'b0;
    cs_start  = 1'b0;
    cs_angle  = yaw_r;
    case (st_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) st_nxt = ST_WRAP;
      end
      ST_WRAP: st_nxt = ST_ANGLE;
      ST_ANGLE: begin
        cs_start = 1'b1;
        cs_angle = c_r.is_tick ? yaw_r : yaw_w;
        st_nxt = ST_COS_YAW;
      end
      ST_COS_YAW: begin
        if (cs_done) begin
          if (c_r.is_tick) st_nxt = ST_MOVE_F;
          else begin
            cs_start = 1'b1;
            cs_angle = pitch_r;
            st_nxt = ST_COS_PITCH;
          end
        end
      end
      ST_COS_PITCH: if (cs_done) st_nxt = ST_DIR_X;
      ST_DIR_X:  st_nxt = ST_DIR_Z;
      ST_DIR_Z:  st_nxt = ST_OUT;
      ST_MOVE_F: st_nxt = ST_MOVE_B;
      ST_MOVE_B: st_nxt = ST_MOVE_L;
      ST_MOVE_L: st_nxt = ST_MOVE_R;
      ST_MOVE_R: st_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      yaw_r       <= YAW_RST;
      pitch_r     <= '0;
      dir_x_r     <= '0;
      dir_y_r     <= '0;
      dir_z_r     <= -16'sd32768;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (cmd_valid) c_r <= cmd;
        ST_WRAP: wq_r <= wq;
        ST_ANGLE: if (!c_r.is_tick) begin
          yaw_r   <= yaw_w;
          pitch_r <= pitch_c;
        end
        ST_COS_YAW: if (cs_done) begin
          sy_r <= cs_sin; cy_r <= cs_cos;
        end
        ST_COS_PITCH: if (cs_done) begin
          cp_r <= cs_cos; dir_y_r <= cs_sin;
        end
        ST_DIR_X: dir_x_r <= mq;
        ST_DIR_Z: dir_z_r <= mq;
        ST_MOVE_F, ST_MOVE_B, ST_MOVE_L, ST_MOVE_R: begin
          if ((st_r == ST_MOVE_F && c_r.keys[0]) || (st_r == ST_MOVE_B && c_r.keys[1]) ||
              (st_r == ST_MOVE_L && c_r.keys[2]) || (st_r == ST_MOVE_R && c_r.keys[3])) begin
            px_r <= nx[PW-1:0];
            pz_r <= nz[PW-1:0];
            if (st_r == ST_MOVE_F || st_r == ST_MOVE_B) py_r <= ny[PW-1:0];
          end
        end
        ST_OUT: if (!out_valid_r || out_ready) begin
          vx_o_r <= dir_x_r; vy_o_r <= dir_y_r; vz_o_r <= dir_z_r;
          px_o_r <= px_r; py_o_r <= py_r; pz_o_r <= pz_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign view_x     = vx_o_r;
  assign view_y     = vy_o_r;
  assign view_z     = vz_o_r;
  assign position_x = px_o_r;
  assign position_y = py_o_r;
  assign position_z = pz_o_r;

endmodule
`default_nettype wire

>>> hdl/fps_camera_look_and_move_unit.sv
`default_nettype none
// First-person camera unit. Mouse beats (tuser = 0) turn the view by the
// cursor delta times look sensitivity; tick beats (tuser = 1) move the
// position along the view and right vectors by speed times time step. Each
// input beat yields one output beat with the view direction and position.
// A mouse beat runs two 18-step CORDIC passes that share one rotator, a
// tick beat one pass plus four movement steps. A one-beat queue sits
// between the decoder and the sequencer and the output register holds a
// result while the next beat is taken.
module fps_camera_look_and_move_unit
  import fcam_pkg::*;
#(
  parameter int CURSOR_BITS   = CURSOR_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [15:0]                  cfg_data,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // cursor_x, cursor_y, time_step, keys_held (low to high), byte padded
  input  wire logic [((2*CURSOR_BITS+20+7)/8)*8-1:0] in_tdata,
  // opcode
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // view_x, view_y, view_z, position_x, position_y, position_z (low to high)
  output logic [((48+3*POSITION_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int CB = CURSOR_BITS;
  localparam int PB = POSITION_BITS;
  localparam int OW = ((48+3*PB+7)/8)*8;

  logic [15:0] look_sens_r, move_speed_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_sens_r  <= LOOK_SENS_RST;
      move_speed_r <= MOVE_SPEED_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOOK_SENS) look_sens_r <= cfg_data;
      if (cfg_index == CFG_MOVE_SPEED) move_speed_r <= cfg_data;
    end
  end

  logic      cmd_valid, cmd_ready;
  fcam_cmd_t cmd;
  logic signed [15:0] vx, vy, vz;
  logic signed [PB-1:0] px, py, pz;

  fcam_front #(.CURSOR_BITS(CB)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tuser), .cursor_x(in_tdata[CB-1:0]), .cursor_y(in_tdata[2*CB-1:CB]),
    .time_step(in_tdata[2*CB+15:2*CB]), .keys_held(in_tdata[2*CB+19:2*CB+16]),
    .look_sens(look_sens_r), .move_speed(move_speed_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  fcam_back #(.POSITION_BITS(PB)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .view_x(vx), .view_y(vy), .view_z(vz),
    .position_x(px), .position_y(py), .position_z(pz)
  );

  assign out_tdata = OW'({pz, py, px, vz, vy, vx});

endmodule
`default_nettype wire

>>> test/fps_camera_look_and_move_unit_tb.sv
`timescale 1ns / 100ps
module fps_camera_look_and_move_unit_tb;
  import fcam_pkg::*;

  localparam int RUN_LIMIT    = 800000;
  localparam int RANDOM_BEATS = 1550;
  localparam int NUM_PHASES   = 7;
  localparam longint POS_MAX  = 64'sd2147483647;
  localparam longint POS_MIN  = -64'sd2147483648;

  // Laid out as the output bus, highest field first.
  typedef struct packed {
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic signed [15:0] vz;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } cam_result_t;

  typedef struct {
    logic        op;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [15:0] dt;
    logic [3:0]  keys;
  } cam_event_t;

  typedef struct {
    cam_event_t  ev;
    bit          typed;
    cam_result_t res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  fps_camera_look_and_move_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Camera model state.
  longint cam_sens, cam_speed;
  longint last_cx, last_cy;
  bit     seed_pending;
  longint yaw, pitch;
  longint dir_x, dir_y, dir_z;
  longint pos_x, pos_y, pos_z;

  cam_result_t pending_views[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int mouse_beats = 0, tick_beats = 0, checked_beats = 0;
  logic [15:0] stall_lfsr = 16'hace1;

  const longint atan_deg[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_q15(input longint v);
    return clamp((v + 16384) >>> 15, -32768, 32767);
  endfunction

  // Folded 18-step CORDIC in Q2.30, angle in Q16 degrees.
  task automatic cordic_sin_cos(input longint angle, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032875;
    y = 0;
    z = angle;
    flip = 0;
    if (z > 90 * 65536) begin
      z -= 180 * 65536;
      flip = 1;
    end else if (z < -90 * 65536) begin
      z += 180 * 65536;
      flip = 1;
    end
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg[i];
      end else begin
        x += dx; y -= dy; z += atan_deg[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
  endtask

  function automatic longint step_pos(input longint p, input longint comp, input longint step,
                                      input longint sgn);
    return clamp(p + sgn * ((comp * step + (64'sd1 <<< 22)) >>> 23), POS_MIN, POS_MAX);
  endfunction

  task automatic camera_reset();
    cam_sens = LOOK_SENS_RST;
    cam_speed = MOVE_SPEED_RST;
    last_cx = CURSOR_X_RST;
    last_cy = CURSOR_Y_RST;
    seed_pending = 1;
    yaw = -90 * 65536;
    pitch = 0;
    dir_x = 0; dir_y = 0; dir_z = -32768;
    pos_x = 0; pos_y = 0; pos_z = 0;
  endtask

  // Advance the camera by one event and return the view and position after it.
  task automatic camera_advance(input cam_event_t ev, output cam_result_t r);
    longint dx, dy, sy, cyw, sp, cp, step, rx, rz;
    if (ev.op == OP_MOUSE) begin
      if (seed_pending) begin
        last_cx = ev.cx;
        last_cy = ev.cy;
        seed_pending = 0;
      end
      dx = (longint'(ev.cx) - last_cx) * cam_sens * 256;
      dy = (last_cy - longint'(ev.cy)) * cam_sens * 256;
      last_cx = ev.cx;
      last_cy = ev.cy;
      yaw = (yaw + dx + 180 * 65536) % (360 * 65536);
      if (yaw < 0) yaw += 360 * 65536;
      yaw -= 180 * 65536;
      pitch = clamp(pitch + dy, -89 * 65536, 89 * 65536);
      cordic_sin_cos(yaw, sy, cyw);
      cordic_sin_cos(pitch, sp, cp);
      dir_x = round_q15(cyw * cp);
      dir_y = sp;
      dir_z = round_q15(sy * cp);
    end else begin
      step = cam_speed * longint'(ev.dt);
      cordic_sin_cos(yaw, sy, cyw);
      rx = clamp(-sy, -32768, 32767);
      rz = cyw;
      if (ev.keys[0]) begin
        pos_x = step_pos(pos_x, dir_x, step, 1);
        pos_y = step_pos(pos_y, dir_y, step, 1);
        pos_z = step_pos(pos_z, dir_z, step, 1);
      end
      if (ev.keys[1]) begin
        pos_x = step_pos(pos_x, dir_x, step, -1);
        pos_y = step_pos(pos_y, dir_y, step, -1);
        pos_z = step_pos(pos_z, dir_z, step, -1);
      end
      if (ev.keys[2]) begin
        pos_x = step_pos(pos_x, rx, step, -1);
        pos_z = step_pos(pos_z, rz, step, -1);
      end
      if (ev.keys[3]) begin
        pos_x = step_pos(pos_x, rx, step, 1);
        pos_z = step_pos(pos_z, rz, step, 1);
      end
    end
    r.vx = dir_x[15:0]; r.vy = dir_y[15:0]; r.vz = dir_z[15:0];
    r.px = pos_x[31:0]; r.py = pos_y[31:0]; r.pz = pos_z[31:0];
  endtask

  // Send one beat with bursty pacing; the expectation is queued once it is taken.
  task automatic send_event(input cam_event_t ev, input bit typed, input cam_result_t fixed);
    int gap;
    cam_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser <= ev.op;
    in_tdata <= {4'b0, ev.keys, ev.dt, ev.cy, ev.cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    camera_advance(ev, r);
    pending_views.push_back(typed ? fixed : r);
    if (ev.op == OP_MOUSE) mouse_beats++;
    else tick_beats++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Holds the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_LOOK_SENS) cam_sens = val;
    else cam_speed = val;
  endtask

  function automatic cam_event_t random_event(input longint cx_prev, input longint cy_prev);
    cam_event_t ev;
    ev.op = 1'($urandom_range(0, 1));
    ev.cx = 12'($urandom);
    ev.cy = 12'($urandom);
    ev.dt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    ev.keys = 4'($urandom);
    // Mostly small cursor motion so the view sweeps gradually.
    if (ev.op == OP_MOUSE && $urandom_range(0, 9) < 8) begin
      ev.cx = 12'(cx_prev + $urandom_range(0, 80) - 40);
      ev.cy = 12'(cy_prev + $urandom_range(0, 40) - 20);
    end
    return ev;
  endfunction

  // Receiver: stretches of full readiness alternate with a pseudo-random stall pattern.
  always @(posedge clk) begin
    cam_result_t got, want;
    cycles <= cycles + 1;
    stall_lfsr <= {stall_lfsr[14:0],
                   stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
    out_tready <= cycles[10] ? 1'b1 : (stall_lfsr[0] | stall_lfsr[3]);
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", out_tdata);
      end else begin
        want = pending_views.pop_front();
        checked_beats++;
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: view exp %0d %0d %0d got %0d %0d %0d; pos exp %0d %0d %0d got %0d %0d %0d",
                     checked_beats, want.vx, want.vy, want.vz, got.vx, got.vy, got.vz,
                     want.px, want.py, want.pz, got.px, got.py, got.pz);
        end
      end
    end
    if (cycles > RUN_LIMIT) begin
      $display("fps_camera_look_and_move_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    cam_result_t none;
    cam_result_t at_rest;
    cam_event_t ev;
    logic [15:0] phase_sens[NUM_PHASES];
    logic [15:0] phase_speed[NUM_PHASES];
    none = '0;
    at_rest = '{vx: 16'sd0, vy: 16'sd0, vz: -16'sd32768, px: 0, py: 0, pz: 0};
    // Directed rows: op, cursor x, cursor y, time step, keys, typed flag, typed result.
    rows = '{
      '{'{OP_TICK,  12'd0,    12'd0,    16'd1234,  4'd0},  1, at_rest},
      '{'{OP_TICK,  12'hfff,  12'hfff,  16'd0,     4'hf},  1, at_rest},
      '{'{OP_TICK,  12'd0,    12'd0,    16'hffff,  4'hf},  0, none},
      '{'{OP_MOUSE, 12'hfff,  12'd0,    16'hffff,  4'hf},  0, none},
      '{'{OP_MOUSE, 12'd0,    12'hfff,  16'd0,     4'd0},  0, none},
      '{'{OP_MOUSE, 12'd0,    12'd0,    16'd0,     4'd0},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'hffff,  4'd1},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'hffff,  4'd2},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'hffff,  4'd4},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'hffff,  4'd8},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'h8000,  4'd3},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'h8000,  4'hc},  0, none},
      '{'{OP_MOUSE, 12'hfff,  12'hfff,  16'd0,     4'd0},  0, none},
      '{'{OP_MOUSE, 12'h800,  12'h001,  16'd0,     4'd0},  0, none},
      '{'{OP_TICK,  12'hfff,  12'hfff,  16'hffff,  4'hf},  0, none},
      '{'{OP_MOUSE, 12'd100,  12'd2000, 16'd0,     4'd0},  0, none},
      '{'{OP_TICK,  12'd0,    12'd0,    16'd1,     4'd5},  0, none}
    };
    phase_sens  = '{16'd0,     16'hffff, 16'd1,     16'hffff, 16'($urandom), 16'($urandom), 16'd26};
    phase_speed = '{16'd0,     16'hffff, 16'hffff,  16'd0,    16'($urandom), 16'($urandom), 16'd640};

    camera_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].res);

    // Each phase drains the pipeline, reprograms both registers, then runs random beats.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(CFG_LOOK_SENS, phase_sens[p]);
      write_reg(CFG_MOVE_SPEED, phase_speed[p]);
      cfg_we <= 1'b0;
      for (int n = 0; n < RANDOM_BEATS / NUM_PHASES; n++) begin
        ev = random_event(last_cx, last_cy);
        send_event(ev, 0, none);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d mouse beats and %0d tick beats over %0d register settings;",
             mouse_beats, tick_beats, NUM_PHASES + 1);
    $display("%0d output beats checked, %0d mismatches", checked_beats, mismatches);
    if (mismatches == 0) begin
      $display("fps_camera_look_and_move_unit_tb: clean");
    end else begin
      $display("fps_camera_look_and_move_unit_tb: errors");
    end
    $finish;
  end

endmodule
